// ----- rtl/core/mrpt_pkg.sv -----
package mrpt_pkg;
   localparam int unsigned NUM_WIDTH    = 63;
   localparam int unsigned CAND_WIDTH   = 64;
   localparam int unsigned RAND_WIDTH   = 31;
   localparam int unsigned CNT_WIDTH    = 31;
   localparam int unsigned ROUNDS_WIDTH = 3;
   localparam int unsigned MAX_ROUNDS_DEFAULT = 5;
   localparam logic [ROUNDS_WIDTH-1:0] ROUNDS_RESET = 3'd5;
   localparam logic [CNT_WIDTH-1:0] CNT_MAX = {CNT_WIDTH{1'b1}};
   localparam logic [6:0] REPORT_PERIOD_M1 = 7'd99;

   typedef logic [NUM_WIDTH-1:0] num_type;

   // modmul unit handshake
   typedef struct packed {
      logic    start;
      num_type x;
      num_type y;
   } mm_req_type;

   typedef struct packed {
      logic    done;
      num_type prod;
   } mm_rsp_type;

   // residue reduction unit handshake (rand mod m)
   typedef struct packed {
      logic    start;
      num_type a;
      num_type m;
   } rd_req_type;
endpackage

// ----- rtl/core/mrpt_modmul.sv -----
// (x*y) mod m by MSB-first shift-and-add, one multiplier bit per cycle.
module mrpt_modmul
   import mrpt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  num_type    modulus,
   input  mm_req_type req,
   output mm_rsp_type rsp
);
   logic [5:0] bit_ff, bit_in;
   logic       busy_ff, busy_in;
   num_type    acc_ff, acc_in, x_ff, x_in, y_ff, y_in;
   logic       done_ff, done_in;
   logic [NUM_WIDTH:0] dbl, dsub, add, asub;
   num_type    dred;

   always_comb begin
      dbl  = {acc_ff, 1'b0};
      dsub = dbl - {1'b0, modulus};
      dred = dsub[NUM_WIDTH] ? dbl[NUM_WIDTH-1:0] : dsub[NUM_WIDTH-1:0];
      add  = {1'b0, dred} + {1'b0, x_ff};
      asub = add - {1'b0, modulus};
      busy_in = busy_ff;
      bit_in  = bit_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         bit_in  = 6'(NUM_WIDTH - 1);
         acc_in  = '0;
         x_in    = req.x;
         y_in    = req.y;
      end else if (busy_ff) begin
         if (y_ff[bit_ff]) begin
            acc_in = asub[NUM_WIDTH] ? add[NUM_WIDTH-1:0] : asub[NUM_WIDTH-1:0];
         end else begin
            acc_in = dred;
         end
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff <= bit_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;
endmodule

// ----- rtl/core/mrpt_reduce.sv -----
// a mod m by restoring division, one quotient bit per cycle.
module mrpt_reduce
   import mrpt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  rd_req_type req,
   output mm_rsp_type rsp
);
   logic [5:0] bit_ff, bit_in;
   logic       busy_ff, busy_in, done_ff, done_in;
   num_type    rem_ff, rem_in, a_ff, a_in, m_ff, m_in;
   logic [NUM_WIDTH:0] sh, sub;

   always_comb begin
      sh  = {rem_ff, a_ff[bit_ff]};
      sub = sh - {1'b0, m_ff};
      busy_in = busy_ff;
      bit_in  = bit_ff;
      rem_in  = rem_ff;
      a_in    = a_ff;
      m_in    = m_ff;
      done_in = 1'b0;
      if (req.start) begin
         busy_in = 1'b1;
         bit_in  = 6'(NUM_WIDTH - 1);
         rem_in  = '0;
         a_in    = req.a;
         m_in    = req.m;
      end else if (busy_ff) begin
         rem_in = sub[NUM_WIDTH] ? sh[NUM_WIDTH-1:0] : sub[NUM_WIDTH-1:0];
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            bit_in = bit_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff <= bit_in;
      rem_ff <= rem_in;
      a_ff   <= a_in;
      m_ff   <= m_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = rem_ff;
endmodule

// ----- rtl/core/miller_rabin_prime_tracker.sv -----
// Miller-Rabin prime tracker.
// req_ channel: one transaction carries a signed 64-bit candidate and five
// 31-bit random words; accepted when req_valid is high and req_stall low.
// rsp_ channel: one transaction per request with the verdict, the largest
// prime seen so far, the saturating request number and a report flag every
// hundredth request; taken when rsp_valid is high and rsp_stall low.
// csr_ channel: writes the round count (0 acts as 1, above MAX_ROUNDS acts
// as MAX_ROUNDS); write only while idle.
// Trivial candidates (negative, 0 to 4) go straight to the done state and
// then the output state. Otherwise each round first runs one reduction
// for the witness (the odd part of n-1 is stripped meanwhile), then
// square-and-multiply over the odd part plus the squaring chain, at most
// about 125 modular products in the shared shift-add modular multiplier.
// One candidate is processed at a time; req_stall is high from acceptance
// until the result is loaded into the result register. The result register
// holds while rsp_stall is high; a following request is worked on meanwhile
// and waits in its final step until the register is consumed.
// Reset clears the maximum, the counter and sets the round count to 5.
module miller_rabin_prime_tracker
   import mrpt_pkg::*;
#(
   parameter int unsigned MAX_ROUNDS = MAX_ROUNDS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [CAND_WIDTH-1:0] req_candidate,
   input  logic [RAND_WIDTH-1:0]       req_rand_0,
   input  logic [RAND_WIDTH-1:0]       req_rand_1,
   input  logic [RAND_WIDTH-1:0]       req_rand_2,
   input  logic [RAND_WIDTH-1:0]       req_rand_3,
   input  logic [RAND_WIDTH-1:0]       req_rand_4,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_is_prime,
   output logic [NUM_WIDTH-1:0]        rsp_highest_so_far,
   output logic [CNT_WIDTH-1:0]        rsp_request_number,
   output logic                        rsp_report_due,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ROUNDS_WIDTH-1:0]     csr_rounds
);
   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_WIT    = 9'b000000010,  // reduce rand mod (n-4), strip zeros of n-1
      S_PWMUL  = 9'b000000100,  // acc = acc*b
      S_PWSQR  = 9'b000001000,  // b = b*b
      S_CHECK  = 9'b000010000,
      S_SQ     = 9'b000100000,  // x = x*x in the squaring chain
      S_NEXT   = 9'b001000000,
      S_DONE   = 9'b010000000,
      S_OUT    = 9'b100000000
   } state_type;

   localparam logic [ROUNDS_WIDTH-1:0] ROUNDS_CAP = ROUNDS_WIDTH'(MAX_ROUNDS);

   state_type state_ff, state_in;
   logic [ROUNDS_WIDTH-1:0] rounds_ff, rounds_in, round_ff, round_in, k_eff;
   num_type n_ff, n_in, d_ff, d_in, e_ff, e_in, acc_ff, acc_in, b_ff, b_in;
   logic [RAND_WIDTH-1:0] rnd_ff [MAX_ROUNDS], rnd_in [MAX_ROUNDS];
   logic    prime_ff, prime_in, launch, launch_ff;
   num_type max_ff, max_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [6:0] mod_ff, mod_in;
   logic rv_ff, rv_in, rp_ff, rp_in, rd_ff, rd_in;
   num_type rh_ff, rh_in;
   logic [CNT_WIDTH-1:0] rn_ff, rn_in;
   mm_req_type mm_req;
   mm_rsp_type mm_rsp, rd_rsp;
   rd_req_type rd_req;
   logic [RAND_WIDTH-1:0] req_rand [5];
   num_type nm1;
   logic    cand_neg;

   mrpt_modmul u_mul (.clock, .reset, .modulus(n_ff), .req(mm_req), .rsp(mm_rsp));
   mrpt_reduce u_red (.clock, .reset, .req(rd_req), .rsp(rd_rsp));

   assign req_rand[0] = req_rand_0;
   assign req_rand[1] = req_rand_1;
   assign req_rand[2] = req_rand_2;
   assign req_rand[3] = req_rand_3;
   assign req_rand[4] = req_rand_4;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);
   assign cand_neg  = req_candidate[CAND_WIDTH-1];
   assign nm1       = n_ff - num_type'(1);
   assign k_eff     = (rounds_ff == '0) ? ROUNDS_WIDTH'(1) :
                      (rounds_ff > ROUNDS_CAP) ? ROUNDS_CAP : rounds_ff;

   always_comb begin
      state_in = state_ff;
      rounds_in = rounds_ff;
      round_in = round_ff;
      n_in = n_ff; d_in = d_ff; e_in = e_ff; acc_in = acc_ff; b_in = b_ff;
      rnd_in = rnd_ff;
      prime_in = prime_ff;
      launch = 1'b0;
      max_in = max_ff; cnt_in = cnt_ff; mod_in = mod_ff;
      rv_in = rv_ff; rp_in = rp_ff; rh_in = rh_ff; rn_in = rn_ff; rd_in = rd_ff;
      mm_req = '{start: 1'b0, x: acc_ff, y: b_ff};
      rd_req = '{start: 1'b0, a: NUM_WIDTH'(rnd_ff[round_ff]), m: n_ff - num_type'(4)};
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      if (csr_valid && csr_ready) rounds_in = csr_rounds;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               n_in = req_candidate[NUM_WIDTH-1:0];
               for (int i = 0; i < MAX_ROUNDS; i++) rnd_in[i] = req_rand[i];
               round_in = '0;
               if (cand_neg || req_candidate[NUM_WIDTH-1:0] <= num_type'(1)
                   || req_candidate[NUM_WIDTH-1:0] == num_type'(4)) begin
                  prime_in = 1'b0;
                  state_in = S_DONE;
               end else if (req_candidate[NUM_WIDTH-1:0] <= num_type'(3)) begin
                  prime_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  prime_in = 1'b1;
                  state_in = S_NEXT;
               end
            end
         end
         S_NEXT: begin
            // start a witness round; d is reduced to the odd part below
            d_in = nm1;
            rd_req.start = 1'b1;
            state_in = S_WIT;
         end
         S_WIT: begin
            // drop one trailing zero of n-1 per cycle; at most 62 of them,
            // done before the witness reduction finishes
            if (!d_ff[0]) d_in = d_ff >> 1;
            if (rd_rsp.done) begin
               b_in = rd_rsp.prod + num_type'(2);
               acc_in = num_type'(1);
               e_in = d_ff;
               if (d_ff[0]) begin
                  mm_req = '{start: 1'b1, x: acc_ff, y: rd_rsp.prod + num_type'(2)};
                  mm_req.x = num_type'(1);
                  state_in = S_PWMUL;
               end else begin
                  state_in = S_PWSQR;
                  launch = 1'b1;
               end
            end
         end
         S_PWMUL: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.prod;
               mm_req = '{start: 1'b1, x: b_ff, y: b_ff};
               state_in = S_PWSQR;
            end
         end
         S_PWSQR: begin
            if (launch_ff) begin
               mm_req = '{start: 1'b1, x: b_ff, y: b_ff};
            end else if (mm_rsp.done) begin
               b_in = mm_rsp.prod;
               e_in = e_ff >> 1;
               if ((e_ff >> 1) == '0) begin
                  state_in = S_CHECK;
               end else if (e_ff[1]) begin
                  mm_req = '{start: 1'b1, x: acc_ff, y: mm_rsp.prod};
                  state_in = S_PWMUL;
               end else begin
                  mm_req = '{start: 1'b1, x: mm_rsp.prod, y: mm_rsp.prod};
               end
            end
         end
         S_CHECK: begin
            // x = acc, e = d
            if (acc_ff == num_type'(1) || acc_ff == nm1) begin
               state_in = S_DONE;
               if (round_ff + ROUNDS_WIDTH'(1) < k_eff) begin
                  round_in = round_ff + ROUNDS_WIDTH'(1);
                  state_in = S_NEXT;
               end
            end else if (d_ff == nm1) begin
               prime_in = 1'b0;
               state_in = S_DONE;
            end else begin
               mm_req = '{start: 1'b1, x: acc_ff, y: acc_ff};
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            if (mm_rsp.done) begin
               acc_in = mm_rsp.prod;
               d_in = d_ff << 1;
               if (mm_rsp.prod == num_type'(1)) begin
                  prime_in = 1'b0;
                  state_in = S_DONE;
               end else if (mm_rsp.prod == nm1) begin
                  state_in = S_DONE;
                  if (round_ff + ROUNDS_WIDTH'(1) < k_eff) begin
                     round_in = round_ff + ROUNDS_WIDTH'(1);
                     state_in = S_NEXT;
                  end
               end else if ((d_ff << 1) == nm1) begin
                  prime_in = 1'b0;
                  state_in = S_DONE;
               end else begin
                  mm_req = '{start: 1'b1, x: mm_rsp.prod, y: mm_rsp.prod};
               end
            end
         end
         S_DONE: begin
            // wait for the result register to be free, then update tracker state
            if (!rv_ff) begin
               if (cnt_ff != CNT_MAX) begin
                  cnt_in = cnt_ff + CNT_WIDTH'(1);
                  mod_in = (mod_ff == REPORT_PERIOD_M1) ? 7'd0 : mod_ff + 7'd1;
               end
               if (prime_ff && n_ff > max_ff) max_in = n_ff;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            rv_in = 1'b1;
            rp_in = prime_ff;
            rh_in = max_ff;
            rn_in = cnt_ff;
            rd_in = (mod_ff == '0) && (cnt_ff != CNT_MAX);
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rounds_ff <= ROUNDS_RESET;
         max_ff    <= '0;
         cnt_ff    <= '0;
         mod_ff    <= '0;
         rv_ff     <= 1'b0;
         launch_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rounds_ff <= rounds_in;
         max_ff    <= max_in;
         cnt_ff    <= cnt_in;
         mod_ff    <= mod_in;
         rv_ff     <= rv_in;
         launch_ff <= launch;
      end
      round_ff <= round_in;
      n_ff <= n_in; d_ff <= d_in; e_ff <= e_in; acc_ff <= acc_in; b_ff <= b_in;
      rnd_ff <= rnd_in;
      prime_ff <= prime_in;
      rp_ff <= rp_in; rh_ff <= rh_in; rn_ff <= rn_in; rd_ff <= rd_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_is_prime       = rp_ff;
   assign rsp_highest_so_far = rh_ff;
   assign rsp_request_number = rn_ff;
   assign rsp_report_due     = rd_ff;

   // hold the result while the receiver stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rsp_stall |=> rv_ff && $stable(rh_ff))
      else $error("result dropped under stall");
   // no new request while busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> req_stall)
      else $error("request accepted while busy");
   // the maximum never shrinks
   a_max: assert property (@(posedge clock) disable iff (reset)
      max_ff >= $past(max_ff))
      else $error("maximum decreased");
   // a launch pulse leads into the squaring step
   a_launch: assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> state_ff == S_PWSQR)
      else $error("launch outside squaring");
endmodule
